>>> sv/i2t_pkg.sv
// Shared constants, types and helpers for the integer to padded text block.
package i2t_pkg;

  localparam int unsigned MAX_WIDTH = 32;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned FW_W      = 6;
  localparam int unsigned NDIG      = 20;
  localparam int unsigned DIG_W     = $clog2(NDIG);
  localparam int unsigned CNT_W     = $clog2(MAX_WIDTH + 24);
  localparam int unsigned STEP_W    = $clog2(VALUE_W);
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RIDX_W    = ADDR_W - 2;

  localparam logic [RIDX_W-1:0] REG_RADIX = RIDX_W'(0);
  localparam logic [RIDX_W-1:0] REG_LEFT  = RIDX_W'(1);
  localparam logic [RIDX_W-1:0] REG_ZERO  = RIDX_W'(2);
  localparam logic [RIDX_W-1:0] REG_ALT   = RIDX_W'(3);
  localparam logic [RIDX_W-1:0] REG_WIDTH = RIDX_W'(4);

  localparam logic [1:0] RADIX_DEC    = 2'd0;
  localparam logic [1:0] RADIX_HEX_LO = 2'd1;
  localparam logic [1:0] RADIX_HEX_UP = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 7'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 7'h58;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 7'h61;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 7'h41;

  typedef struct packed {
    logic [1:0]      radix_mode;
    logic            left_justify;
    logic            zero_fill;
    logic            alt_prefix;
    logic [FW_W-1:0] field_width;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               hex;
    logic               upper;
    logic               prefix;
    logic               left_justify;
    logic               zero_fill;
    logic [CNT_W-1:0]   width;
  } entry_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] dig, input logic upper);
    logic [CHAR_W-1:0] ch;
    if (dig < 4'd10) begin
      ch = CH_ZERO + CHAR_W'(dig);
    end else if (upper) begin
      ch = CH_A_UP + CHAR_W'(dig - 4'd10);
    end else begin
      ch = CH_A_LO + CHAR_W'(dig - 4'd10);
    end
    return ch;
  endfunction

endpackage

>>> sv/i2t_regs.sv
// Configuration register file with its APB-style access port.
module i2t_regs import i2t_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t              cfg_q;
  logic              wr_en;
  logic [RIDX_W-1:0] ridx;

  assign ridx   = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (ridx)
        REG_RADIX: cfg_q.radix_mode   <= pwdata[1:0];
        REG_LEFT:  cfg_q.left_justify <= pwdata[0];
        REG_ZERO:  cfg_q.zero_fill    <= pwdata[0];
        REG_ALT:   cfg_q.alt_prefix   <= pwdata[0];
        REG_WIDTH: cfg_q.field_width  <= pwdata[FW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (ridx)
      REG_RADIX: prdata = DATA_W'(cfg_q.radix_mode);
      REG_LEFT:  prdata = DATA_W'(cfg_q.left_justify);
      REG_ZERO:  prdata = DATA_W'(cfg_q.zero_fill);
      REG_ALT:   prdata = DATA_W'(cfg_q.alt_prefix);
      REG_WIDTH: prdata = DATA_W'(cfg_q.field_width);
      default:   prdata = '0;
    endcase
  end

endmodule

>>> sv/i2t_front.sv
// Front end: accepts a value and classifies it against the configuration.
module i2t_front import i2t_pkg::*; (
  input  logic               start,
  input  logic [VALUE_W-1:0] value_i,
  input  cfg_t               cfg_i,
  input  logic               full_i,
  output logic               busy,
  output logic               push_o,
  output entry_t             entry_o
);

  logic             hex;
  logic [CNT_W-1:0] fw_ext;

  assign busy   = full_i;
  assign push_o = start && !full_i;
  assign hex    = (cfg_i.radix_mode == RADIX_HEX_LO) || (cfg_i.radix_mode == RADIX_HEX_UP);
  assign fw_ext = CNT_W'(cfg_i.field_width);

  always_comb begin
    entry_o.value        = value_i;
    entry_o.hex          = hex;
    entry_o.upper        = (cfg_i.radix_mode == RADIX_HEX_UP);
    entry_o.prefix       = hex && cfg_i.alt_prefix && (value_i != '0);
    entry_o.left_justify = cfg_i.left_justify;
    entry_o.zero_fill    = cfg_i.zero_fill;
    entry_o.width        = (fw_ext > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : fw_ext;
  end

endmodule

>>> sv/i2t_queue.sv
// Short register queue between the front end and the back end.
module i2t_queue import i2t_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

>>> sv/i2t_back.sv
// Back end: digit conversion, field sizing and character emission.
module i2t_back import i2t_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  entry_t            entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              last_char_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_BOUND,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [VALUE_W-1:0] bin_q;
  logic [3:0]         dig_q [NDIG];
  logic [3:0]         dig_d [NDIG];
  logic [3:0]         adj   [NDIG];
  logic [3:0]         hex_dig [NDIG];
  logic [STEP_W-1:0]  step_q;
  logic               upper_q;
  logic               prefix_q;
  logic               left_q;
  logic               zero_q;
  logic [CNT_W-1:0]   width_q;
  logic [CNT_W-1:0]   nd_q;
  logic [CNT_W-1:0]   nd_calc;
  logic [CNT_W-1:0]   body;
  logic [CNT_W-1:0]   pad;
  logic [CNT_W-1:0]   a_q, b_q, c_q, d_q, total_q;
  logic [CNT_W-1:0]   pos_q;
  logic [CNT_W-1:0]   dig_pos;
  logic [CHAR_W-1:0]  ch;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // One shift-and-add-three step of the binary to decimal conversion.
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      adj[k] = (dig_q[k] >= 4'd5) ? dig_q[k] + 4'd3 : dig_q[k];
    end
    for (int k = 0; k < NDIG; k++) begin
      if (k == 0) begin
        dig_d[k] = {adj[k][2:0], bin_q[VALUE_W-1]};
      end else begin
        dig_d[k] = {adj[k][2:0], adj[k-1][3]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      hex_dig[k] = 4'd0;
    end
    for (int k = 0; k < VALUE_W / 4; k++) begin
      hex_dig[k] = entry_i.value[4*k +: 4];
    end
  end

  always_comb begin
    nd_calc = CNT_W'(1);
    for (int k = 1; k < NDIG; k++) begin
      if (dig_q[k] != 4'd0) begin
        nd_calc = CNT_W'(k + 1);
      end
    end
  end

  assign body    = nd_q + (prefix_q ? CNT_W'(2) : '0);
  assign pad     = (width_q > body) ? width_q - body : '0;
  assign dig_pos = d_q - CNT_W'(1) - pos_q;

  always_comb begin
    if (pos_q < a_q) begin
      ch = CH_SPACE;
    end else if (pos_q < b_q) begin
      ch = (pos_q == a_q) ? CH_ZERO : (upper_q ? CH_X_UP : CH_X_LO);
    end else if (pos_q < c_q) begin
      ch = CH_ZERO;
    end else if (pos_q < d_q) begin
      ch = digit_char(dig_q[dig_pos[DIG_W-1:0]], upper_q);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      pos_q       <= '0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            upper_q  <= entry_i.upper;
            prefix_q <= entry_i.prefix;
            left_q   <= entry_i.left_justify;
            zero_q   <= entry_i.zero_fill;
            width_q  <= entry_i.width;
            bin_q    <= entry_i.value;
            step_q   <= '0;
            for (int k = 0; k < NDIG; k++) begin
              dig_q[k] <= entry_i.hex ? hex_dig[k] : 4'd0;
            end
            state_q <= entry_i.hex ? S_SIZE : S_CONV;
          end
        end
        S_CONV: begin
          dig_q  <= dig_d;
          bin_q  <= {bin_q[VALUE_W-2:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(VALUE_W - 1)) begin
            state_q <= S_SIZE;
          end
        end
        S_SIZE: begin
          nd_q    <= nd_calc;
          state_q <= S_BOUND;
        end
        S_BOUND: begin
          a_q     <= (!left_q && !zero_q) ? pad : '0;
          b_q     <= ((!left_q && !zero_q) ? pad : '0) + (prefix_q ? CNT_W'(2) : '0);
          c_q     <= (left_q ? '0 : pad) + (prefix_q ? CNT_W'(2) : '0);
          d_q     <= (left_q ? '0 : pad) + body;
          total_q <= pad + body;
          pos_q   <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_q <= 1'b1;
          char_q      <= ch;
          last_q      <= (pos_q == total_q - CNT_W'(1));
          pos_q       <= pos_q + 1'b1;
          if (pos_q == total_q - CNT_W'(1)) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == S_EMIT))
    else $error("character word outside emission");

  a_last_ends_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_char_o) |-> (state_q == S_IDLE))
    else $error("emission continues after last character");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q != S_IDLE))
    else $error("pop did not start a conversion");

  a_digits_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (d_q <= total_q && nd_q != '0))
    else $error("field bounds inconsistent");

endmodule

>>> sv/integer_to_padded_text_top.sv
// Top level of the integer to padded text formatter.
//
// A command word is taken on value_i at a clock edge where start is high and
// busy is low. Each word produces its printf-style text, one ASCII character
// per cycle on char_code_o, marked by out_valid_o for exactly one cycle, with
// last_char_o set on the final character. The receiver cannot stall.
// The front end classifies a word against the configuration and places it in
// a two-entry queue, so up to two words wait while the back end works.
// The back end loads a word, runs 64 shift-and-add-three steps for decimal
// (none for hex), sizes the field in S_SIZE and S_BOUND, then emits it. A new
// word is taken from the queue only once the back end is idle again.
// Configuration is to be written over the APB-style port only while the
// block is idle, by the user; the block itself does not enforce this.
// Reset clears the registers, the queue and the back-end sequencer.
module integer_to_padded_text_top import i2t_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  output logic [CHAR_W-1:0]  char_code_o,
  output logic               last_char_o
);

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  i2t_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2t_front u_front (
    .start   (start),
    .value_i (value_i),
    .cfg_i   (cfg),
    .full_i  (full),
    .busy    (busy),
    .push_o  (push),
    .entry_o (push_entry)
  );

  i2t_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  i2t_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

>>> test/padded_text_checker.sv
// Checker for the integer to padded text block: predicts each character and compares it.
module padded_text_checker import i2t_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               out_valid_o,
  input  logic [CHAR_W-1:0]  char_code_o,
  input  logic               last_char_o,
  output int unsigned        fail_count,
  output int unsigned        pending_count,
  output int unsigned        char_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } glyph_t;

  glyph_t            expected_glyphs[$];
  logic [1:0]        fmt_radix;
  logic              fmt_left;
  logic              fmt_zero;
  logic              fmt_alt;
  logic [FW_W-1:0]   fmt_width;
  int unsigned       mismatches;
  int unsigned       seen_chars;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] dig, input bit upper);
    if (dig < 4'd10) return CH_ZERO + CHAR_W'(dig);
    return (upper ? CH_A_UP : CH_A_LO) + CHAR_W'(dig) - CHAR_W'(10);
  endfunction

  function automatic void render_text(input logic [VALUE_W-1:0] number);
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] digit_text[$];
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] base;
    bit                 is_hex;
    bit                 is_upper;
    bit                 has_prefix;
    int unsigned        width;
    int unsigned        body;
    int unsigned        pad;
    glyph_t             g;
    is_hex     = (fmt_radix == RADIX_HEX_LO) || (fmt_radix == RADIX_HEX_UP);
    is_upper   = (fmt_radix == RADIX_HEX_UP);
    has_prefix = is_hex && fmt_alt && (number != '0);
    base       = is_hex ? VALUE_W'(16) : VALUE_W'(10);
    rest       = number;
    do begin
      digit_text.push_front(digit_glyph(4'(rest % base), is_upper));
      rest = rest / base;
    end while (rest != '0);
    body  = digit_text.size() + (has_prefix ? 2 : 0);
    width = (fmt_width > MAX_WIDTH) ? MAX_WIDTH : fmt_width;
    pad   = (width > body) ? width - body : 0;
    if (!fmt_left && !fmt_zero) repeat (pad) text = {text, CH_SPACE};
    if (has_prefix) begin
      text = {text, CH_ZERO};
      text = {text, (is_upper ? CH_X_UP : CH_X_LO)};
    end
    if (!fmt_left && fmt_zero) repeat (pad) text = {text, CH_ZERO};
    foreach (digit_text[i]) text = {text, digit_text[i]};
    if (fmt_left) repeat (pad) text = {text, CH_SPACE};
    foreach (text[i]) begin
      g.code = text[i];
      g.last = (i == text.size() - 1);
      expected_glyphs = {expected_glyphs, g};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t want;
    if (!rst_ni) begin
      fmt_radix = RADIX_DEC;
      fmt_left = 1'b0;
      fmt_zero = 1'b0;
      fmt_alt = 1'b0;
      fmt_width = '0;
      expected_glyphs.delete();
      mismatches = 0;
      seen_chars = 0;
      fail_count <= 0;
      pending_count <= 0;
      char_count <= 0;
    end else begin
      if (out_valid_o === 1'b1) begin
        seen_chars++;
        if (expected_glyphs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, got char %h last %b",
                   $time, char_code_o, last_char_o);
        end else begin
          want = expected_glyphs.pop_front();
          if (char_code_o !== want.code) begin
            mismatches++;
            $display("%0t: char_code mismatch: expected %h, got %h",
                     $time, want.code, char_code_o);
          end
          if (last_char_o !== want.last) begin
            mismatches++;
            $display("%0t: last_char mismatch: expected %b, got %b",
                     $time, want.last, last_char_o);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) render_text(value_i);
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_RADIX: fmt_radix = pwdata[1:0];
          REG_LEFT:  fmt_left  = pwdata[0];
          REG_ZERO:  fmt_zero  = pwdata[0];
          REG_ALT:   fmt_alt   = pwdata[0];
          REG_WIDTH: fmt_width = pwdata[FW_W-1:0];
          default: ;
        endcase
      end
      fail_count <= mismatches;
      pending_count <= expected_glyphs.size();
      char_count <= seen_chars;
    end
  end

endmodule

>>> test/integer_to_padded_text_top_tb.sv
// Testbench top for the integer to padded text block: stimulus, configuration and verdict.
module integer_to_padded_text_top_tb import i2t_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  RADIX_ALT_DEC = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_WORDS   = 32;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic [CHAR_W-1:0]  char_code_o;
  logic               last_char_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned char_count;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned format_count;
  bit          start_high;
  bit          steady;

  integer_to_padded_text_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .value_i, .out_valid_o, .char_code_o, .last_char_o
  );

  padded_text_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start, .busy, .value_i, .out_valid_o, .char_code_o, .last_char_o,
    .fail_count, .pending_count, .char_count
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d characters outstanding.",
               cycle_count, pending_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_format(input logic [1:0] radix, input logic left, input logic zero,
                            input logic alt, input logic [FW_W-1:0] width);
    logic [DATA_W-1:0] data;
    data = $urandom;
    data[1:0] = radix;
    write_reg(REG_RADIX, data);
    data = $urandom;
    data[0] = left;
    write_reg(REG_LEFT, data);
    data = $urandom;
    data[0] = zero;
    write_reg(REG_ZERO, data);
    data = $urandom;
    data[0] = alt;
    write_reg(REG_ALT, data);
    data = $urandom;
    data[FW_W-1:0] = width;
    write_reg(REG_WIDTH, data);
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_WIDTH + RIDX_W'(1) + RIDX_W'($urandom_range(0, 2)), $urandom);
    format_count++;
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] number);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      if (start_high) start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    value_i <= number;
    start_high = 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic drain;
    if (start_high) begin
      start <= 1'b0;
      start_high = 1'b0;
    end
    do @(posedge clk_i); while (pending_count != 0);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = v >> $urandom_range(1, 63);
      1: v = v >> $urandom_range(44, 63);
      2: v = VALUE_W'(v[3:0]);
      3: v = v[0] ? '1 : '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [FW_W-1:0] pick_width();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return FW_W'(MAX_WIDTH);
      2: return '1;
      default: return FW_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    value_i <= '0;
    cycle_count <= 0;
    sent_count = 0;
    format_count = 0;
    start_high = 1'b0;
    steady = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset format: plain decimal with no field width.
    send_value('0);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'd10000000000000000000);
    send_value(64'd9999999999999999999);
    drain();
    // Zero with the alternate flag gets zero fill and no prefix.
    set_format(RADIX_HEX_LO, 1'b0, 1'b1, 1'b1, FW_W'(20));
    send_value('0);
    send_value(64'd1);
    send_value(64'hABCDEF);
    send_value('1);
    drain();
    // Left justify overrides zero fill, and an oversize width saturates.
    set_format(RADIX_HEX_UP, 1'b1, 1'b1, 1'b1, '1);
    send_value('0);
    send_value(64'hDEADBEEF);
    send_value('1);
    drain();
    set_format(RADIX_ALT_DEC, 1'b0, 1'b0, 1'b1, FW_W'(5));
    send_value('0);
    send_value(64'd123456);
    send_value('1);
    drain();
    set_format(RADIX_HEX_UP, 1'b0, 1'b0, 1'b1, FW_W'(18));
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h0FED_CBA9_8765_4321);
    drain();
    set_format(RADIX_DEC, 1'b1, 1'b0, 1'b0, FW_W'(MAX_WIDTH));
    send_value(64'd1);
    send_value('1);
    drain();
    set_format(RADIX_HEX_LO, 1'b0, 1'b0, 1'b0, '0);
    send_value(64'hFEDC_BA98_7654_3210);
    drain();

    repeat (PHASES) begin
      set_format(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
                 pick_width());
      steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) begin
        send_value(pick_value());
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Sent %0d values under %0d formats and checked %0d characters.",
             sent_count, format_count, char_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
